// ===== design/pmf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Monitoring packet framer package
// Shared sizes, codes, result type and the CRC, hex and BCD helper functions.
// ----------------------------------------------------------------------------
package pmf_pkg;

  localparam int MAX_PAYLOAD = 1024;
  localparam int ADDR_W      = $clog2(MAX_PAYLOAD);
  localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);
  localparam int POS_W       = $clog2(MAX_PAYLOAD + 12);

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_PULL = 1'b1;

  localparam logic [7:0] CHR_HASH = 8'h23;
  localparam logic [7:0] CHR_CR   = 8'h0D;
  localparam logic [7:0] CHR_LF   = 8'h0A;
  localparam logic [7:0] CHR_ZERO = 8'h30;
  localparam logic [7:0] CHR_HEXA = 8'h37;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NO_FRAME = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_BUSY     = 2'd3
  } status_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] out_byte;
    logic       frame_end;
    status_t    status;
  } res_t;

  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = {8'h00, crc[15:8] ^ b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [7:0] hex_ascii(input logic [3:0] n);
    return (n < 4'd10) ? (CHR_ZERO | {4'h0, n}) : (CHR_HEXA + {4'h0, n});
  endfunction

  function automatic logic [15:0] bcd_inc(input logic [15:0] v);
    logic [15:0] r;
    logic        carry;
    r     = v;
    carry = 1'b1;
    for (int i = 0; i < 4; i++) begin
      if (carry) begin
        if (r[4*i +: 4] == 4'd9) begin
          r[4*i +: 4] = 4'd0;
        end else begin
          r[4*i +: 4] = r[4*i +: 4] + 4'd1;
          carry       = 1'b0;
        end
      end
    end
    return r;
  endfunction

endpackage

// ===== design/pmf_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Payload memory
// Simple dual-port synchronous RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module pmf_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/pmf_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Framing engine
// Holds the frame state, folds loaded bytes into the CRC and the payload
// memory, and forms each result from the read-back byte or the frame fields.
// ----------------------------------------------------------------------------
module pmf_engine
  import pmf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic       req_type,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  input  logic       res_take,
  output res_t       res
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_WORK = 2'b10
  } state_t;

  localparam logic [POS_W-1:0] POS_TWO  = POS_W'(2);
  localparam logic [POS_W-1:0] POS_FOUR = POS_W'(4);
  localparam logic [POS_W-1:0] POS_SIX  = POS_W'(6);

  state_t           state;
  logic [CNT_W-1:0] count;
  logic [15:0]      bcd;
  logic [15:0]      crc;
  logic             draining;
  logic [POS_W-1:0] position;

  logic             w_type;
  logic [7:0]       w_byte;
  logic             w_last;

  logic [POS_W-1:0] body_end;
  logic [POS_W-1:0] hex_rel;
  logic [POS_W-1:0] pos_body;
  logic [1:0]       dig_sel;
  logic [3:0]       digit;
  logic [3:0]       nibble;
  logic             room;
  logic             commit;
  logic             store;
  logic [7:0]       rd_data;

  assign body_end = POS_W'(count) + POS_SIX;
  assign hex_rel  = position - body_end;
  assign pos_body = position - POS_SIX;
  assign dig_sel  = position[1:0] - POS_TWO[1:0];
  assign room     = count < CNT_W'(MAX_PAYLOAD);
  assign commit   = (state == S_WORK) && res_take;
  assign store    = commit && (w_type == REQ_LOAD) && !draining && room;

  always_comb begin
    unique case (dig_sel)
      2'd0:    digit = bcd[15:12];
      2'd1:    digit = bcd[11:8];
      2'd2:    digit = bcd[7:4];
      default: digit = bcd[3:0];
    endcase
  end

  always_comb begin
    unique case (hex_rel[1:0])
      2'd0:    nibble = crc[15:12];
      2'd1:    nibble = crc[11:8];
      2'd2:    nibble = crc[7:4];
      default: nibble = crc[3:0];
    endcase
  end

  always_comb begin
    res.valid     = (state == S_WORK);
    res.out_byte  = 8'h00;
    res.frame_end = 1'b0;
    res.status    = STAT_OK;
    if (w_type == REQ_LOAD) begin
      if (draining) begin
        res.status = STAT_BUSY;
      end else if (!room) begin
        res.status = STAT_FULL;
      end
    end else if (!draining) begin
      res.status = STAT_NO_FRAME;
    end else if (position < POS_TWO) begin
      res.out_byte = CHR_HASH;
    end else if (position < POS_SIX) begin
      res.out_byte = CHR_ZERO | {4'h0, digit};
    end else if (position < body_end) begin
      res.out_byte = rd_data;
    end else if (position < body_end + POS_FOUR) begin
      res.out_byte = hex_ascii(nibble);
    end else if (position == body_end + POS_FOUR) begin
      res.out_byte = CHR_CR;
    end else begin
      res.out_byte  = CHR_LF;
      res.frame_end = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      bcd      <= '0;
      crc      <= CRC_INIT;
      draining <= 1'b0;
      position <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_WORK;
          end
        end
        S_WORK: begin
          if (commit) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (commit) begin
        if (w_type == REQ_LOAD) begin
          if (!draining) begin
            if (room) begin
              crc   <= crc_fold(crc, w_byte);
              count <= count + CNT_W'(1);
              bcd   <= bcd_inc(bcd);
            end
            if (w_last) begin
              draining <= 1'b1;
              position <= '0;
            end
          end
        end else if (draining) begin
          if (res.frame_end) begin
            count    <= '0;
            bcd      <= '0;
            crc      <= CRC_INIT;
            draining <= 1'b0;
            position <= '0;
          end else begin
            position <= position + POS_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      w_type <= req_type;
      w_byte <= data_byte;
      w_last <= last_byte;
    end
  end

  // Reads are issued on acceptance and writes on completion, so the two never
  // fall in the same cycle and no forwarding path is needed.
  pmf_ram #(
    .DEPTH (MAX_PAYLOAD),
    .WIDTH (8)
  ) u_ram (
    .clk     (clk),
    .wr_en   (store),
    .wr_addr (count[ADDR_W-1:0]),
    .wr_data (w_byte),
    .rd_en   (accept),
    .rd_addr (pos_body[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

endmodule

// ===== design/monitoring_packet_framer_crc16_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Monitoring packet framer with CRC-16
// Loads payload bytes into a memory with a running CRC and drains them as a
// framed packet: hashes, decimal length, payload, hex CRC, CR LF.
//
//   Channel  Handshake            Payload
//   req      req_valid/req_stall  req_type, data_byte, last_byte
//   rsp      rsp_valid/rsp_stall  out_byte, frame_end, status
//
// Each request passes through the payload memory read and then the forming of
// the result; no new request is taken while one is still in the engine.
// The result is held in an output register, one request may be in the engine
// while it waits. Reset is synchronous; the payload memory is not cleared.
// A stalled response holds the engine once its next request is taken.
// ----------------------------------------------------------------------------
module monitoring_packet_framer_crc16_top
  import pmf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  logic       req_type,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  output logic [7:0] out_byte,
  output logic       frame_end,
  output logic [1:0] status
);

  res_t res;
  logic accept;
  logic res_take;

  assign req_stall = res.valid;
  assign accept    = req_valid && !req_stall;
  assign res_take  = res.valid && (!rsp_valid || !rsp_stall);

  pmf_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .req_type  (req_type),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .res_take  (res_take),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_take) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_byte  <= res.out_byte;
      frame_end <= res.frame_end;
      status    <= res.status;
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> req_stall)
    else $error("engine did not hold off after taking a request");

  a_end_is_lf: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && frame_end) |-> (status == STAT_OK && out_byte == CHR_LF))
    else $error("frame end without a good LF");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && status != STAT_OK) |-> (out_byte == 8'h00 && !frame_end))
    else $error("error response carries data");

endmodule
